### hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the streaming Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Width of the running byte counter; it saturates at all ones.
    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 4;
    localparam int RIDX_BITS   = $clog2(MAX_RESULTS);
    localparam int RCOUNT_BITS = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Kind of one input character.
    typedef enum logic [1:0] {
        CH_SEXTET,
        CH_SPACE,
        CH_PAD,
        CH_BAD
    } ch_kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic        status;
        logic [15:0] byte_total;
        logic        last_result;
    } out_item_t;

    // All results caused by one input transaction, in delivery order.
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        logic [RCOUNT_BITS-1:0]      n;
    } bundle_t;

    // Saturating add of a small step to the byte counter.
    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                      input logic [1:0] k);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS + 1)'(k);
        if (s[COUNT_BITS])
            return '1;
        return s[COUNT_BITS-1:0];
    endfunction

    // Clamp the counter to the 16-bit reported total.
    function automatic logic [15:0] report_total(input logic [COUNT_BITS-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        if (w > 33'h0_FFFF)
            return 16'hFFFF;
        return w[15:0];
    endfunction

endpackage

### hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, tracks sextet state and builds the result bundle.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  b64d_pkg::in_item_t   item,
    output logic                 push,
    output b64d_pkg::bundle_t    bundle
);

    typedef struct packed {
        b64d_pkg::ch_kind_t kind;
        logic [5:0]         value;
    } ch_class_t;

    function automatic ch_class_t classify(input logic [7:0] c);
        ch_class_t r;
        logic [7:0] d;
        r.kind  = b64d_pkg::CH_BAD;
        r.value = '0;
        d       = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            r.kind = b64d_pkg::CH_SEXTET;
            r.value = d[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            r.kind = b64d_pkg::CH_SEXTET;
            r.value = d[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            r.kind = b64d_pkg::CH_SEXTET;
            r.value = d[5:0];
        end else if (c == 8'h2B || c == 8'h2D) begin
            r.kind = b64d_pkg::CH_SEXTET;
            r.value = 6'd62;
        end else if (c == 8'h2F || c == 8'h5F) begin
            r.kind = b64d_pkg::CH_SEXTET;
            r.value = 6'd63;
        end else if (c == 8'h3D) begin
            r.kind = b64d_pkg::CH_PAD;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            r.kind = b64d_pkg::CH_SPACE;
        end
        return r;
    endfunction

    logic [5:0]                    hold_reg [3];
    logic [5:0]                    hold_next [3];
    logic [1:0]                    count_reg, count_next;
    logic                          pad_reg, pad_next;
    logic                          err_reg, err_next;
    logic [b64d_pkg::COUNT_BITS-1:0] done_reg, done_next;

    ch_class_t                     cls;
    logic                          active;
    logic                          last;
    logic                          quad;
    logic [7:0]                    data_byte [3];
    logic [1:0]                    nd;
    logic [b64d_pkg::COUNT_BITS-1:0] after_data;

    always_comb
    begin
        cls        = classify(item.char_code);
        active     = accept && item.char_present && !pad_reg && !err_reg;
        last       = accept && item.end_of_input;
        hold_next  = hold_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        quad       = 1'b0;

        if (active)
        begin
            case (cls.kind)
                b64d_pkg::CH_SEXTET:
                begin
                    if (count_reg == 2'd3)
                    begin
                        quad       = 1'b1;
                        count_next = 2'd0;
                    end
                    else
                    begin
                        hold_next[count_reg] = cls.value;
                        count_next           = count_reg + 2'd1;
                    end
                end
                b64d_pkg::CH_PAD:   pad_next = 1'b1;
                b64d_pkg::CH_BAD:   err_next = 1'b1;
                b64d_pkg::CH_SPACE: ;
                default:  ;
            endcase
        end

        // A full quad emits three bytes; otherwise the end flushes leftovers.
        data_byte[2] = {hold_reg[2][1:0], cls.value};
        data_byte[0] = {hold_next[0], hold_next[1][5:4]};
        data_byte[1] = {hold_next[1][3:0], hold_next[2][5:2]};
        nd = 2'd0;
        if (quad)
            nd = 2'd3;
        else if (last && !err_next && count_next == 2'd3)
            nd = 2'd2;
        else if (last && !err_next && count_next == 2'd2)
            nd = 2'd1;

        after_data = b64d_pkg::sat_add(done_reg, nd);

        bundle.n = b64d_pkg::RCOUNT_BITS'(nd) + b64d_pkg::RCOUNT_BITS'(last);
        for (int i = 0; i < b64d_pkg::MAX_RESULTS; i++)
        begin
            bundle.items[i] = '0;
            if (i < 3 && 2'(i) < nd)
            begin
                bundle.items[i].out_byte   = data_byte[i < 3 ? i : 0];
                bundle.items[i].is_data    = 1'b1;
                bundle.items[i].byte_total =
                    b64d_pkg::report_total(b64d_pkg::sat_add(done_reg, 2'(i + 1)));
            end
            else if (3'(i) == {1'b0, nd} && last)
            begin
                bundle.items[i].status     = err_next;
                bundle.items[i].byte_total = b64d_pkg::report_total(after_data);
            end
            bundle.items[i].last_result =
                (b64d_pkg::RCOUNT_BITS'(i) + b64d_pkg::RCOUNT_BITS'(1)) == bundle.n;
        end
        push = accept && (bundle.n != '0);

        done_next = accept ? after_data : done_reg;
        if (last)
        begin
            hold_next  = '{default: '0};
            count_next = '0;
            pad_next   = 1'b0;
            err_next   = 1'b0;
            done_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '{default: '0};
            count_reg <= '0;
            pad_reg   <= 1'b0;
            err_reg   <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            hold_reg  <= hold_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
        end
    end

endmodule

### hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short bundle queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::bundle_t wr_data,
    input  logic              pop,
    output b64d_pkg::bundle_t rd_data,
    output logic              not_empty,
    output logic              full
);

    b64d_pkg::bundle_t                 entry_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QCOUNT_BITS-1:0]  count_reg, count_next;

    assign rd_data   = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == b64d_pkg::QCOUNT_BITS'(b64d_pkg::QUEUE_DEPTH));

    function automatic logic [b64d_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [b64d_pkg::QPTR_BITS-1:0] p);
        if (p == b64d_pkg::QPTR_BITS'(b64d_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + b64d_pkg::QPTR_BITS'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + b64d_pkg::QCOUNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - b64d_pkg::QCOUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Serializes queued bundles into single results behind an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64d_pkg::bundle_t     head,
    input  logic                  head_valid,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output b64d_pkg::out_item_t   result_data
);

    logic [b64d_pkg::RIDX_BITS-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;
    b64d_pkg::out_item_t            data_reg, data_next;
    logic                           load;

    always_comb
    begin
        load = head_valid && (!valid_reg || !result_stall);
        pop  = load && ((b64d_pkg::RCOUNT_BITS'(idx_reg) + b64d_pkg::RCOUNT_BITS'(1))
                        == head.n);
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            data_next  = head.items[idx_reg];
            valid_next = 1'b1;
            idx_next   = pop ? '0 : idx_reg + b64d_pkg::RIDX_BITS'(1);
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

### hdl/base64url_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Streaming Base64 decoder (URL-safe and standard alphabets), one char per item.
// ----------------------------------------------------------------------------
// Input channel char_valid / char_stall / char_data carries one character
// per transaction, with a present flag and an end-of-input mark. Output
// channel result_valid / result_stall / result_data carries one result per
// transaction: a decoded byte, or the end status with the byte count.
// A transaction completes on a clock edge with valid high and stall low.
//
// Each character's results are written to the bundle queue at the edge that
// takes it, then pass through the output register to the port.
// Throughput: one character per cycle while results average at most one per
// character. A quad-completing character makes three results and an end mark
// adds one more; the port drains one per cycle, a two-entry bundle queue
// absorbs the burst, and char_stall rises only while that queue is full.
// Reset clears the decoder state, the queue pointers and the output valid
// flag. When the receiver stalls, the output register holds its result,
// the queue fills, and then char_stall rises.
// ----------------------------------------------------------------------------
module base64url_stream_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  b64d_pkg::in_item_t   char_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output b64d_pkg::out_item_t  result_data
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_not_empty;
    b64d_pkg::bundle_t wr_bundle;
    b64d_pkg::bundle_t head_bundle;

    // Stall the source only while the queue has no free entry.
    assign char_stall = q_full;
    assign accept     = char_valid && !char_stall;

    // Front: classify, advance sextet state, build results of this transaction.
    b64d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_data),
        .push   (push),
        .bundle (wr_bundle)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_bundle),
        .pop       (pop),
        .rd_data   (head_bundle),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Back: drain one result per cycle into the output register when not stalled.
    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_bundle),
        .head_valid   (q_not_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

### hdl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_stall,
    input b64d_pkg::out_item_t  result_data
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // The end status closes the transaction's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.is_data |-> result_data.last_result)
        else $error("end status not marked last");

    // Data results never carry an error status.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.is_data |-> !result_data.status)
        else $error("data result with status set");

    // The end status carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.is_data |-> result_data.out_byte == 8'd0)
        else $error("end status with nonzero byte");

endmodule

bind base64url_stream_decoder b64d_checker u_checker (.*);

### bench/base64url_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder_tb
// Self-checking bench for the streaming Base64 decoder. A queue-fed driver
// offers one character per transaction. A predictor turns each accepted
// character into the bytes and end status it should produce. A monitor
// compares every result transaction with the oldest prediction. The
// stimulus covers both alphabets, whitespace, padding, invalid characters,
// broken strings and random noise.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_tb;

    localparam int IDLE_PCT  = 34;
    localparam int HOLD_LEN  = 300;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 char_valid   = 1'b0;
    logic                 char_stall;
    b64d_pkg::in_item_t   char_data    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    b64d_pkg::out_item_t  result_data;

    // Stimulus waiting for the driver, and results waiting for the monitor.
    b64d_pkg::in_item_t   char_queue[$];
    b64d_pkg::out_item_t  expected_results[$];

    // Predictor copy of the decoder state.
    logic [5:0]                      sextet_buf[3] = '{6'd0, 6'd0, 6'd0};
    logic [1:0]                      sextet_cnt    = 2'd0;
    logic                            pad_seen      = 1'b0;
    logic                            bad_seen      = 1'b0;
    logic [b64d_pkg::COUNT_BITS-1:0] decoded_bytes = '0;

    // Run control shared by the stimulus block, the driver and the receiver.
    logic        char_taken   = 1'b0;
    logic        calm         = 1'b0;
    logic        hold_req     = 1'b0;
    logic        hold_done    = 1'b0;
    int          hold_left    = 0;

    int          errors          = 0;
    int          strings_sent    = 0;
    int          chars_planned   = 0;
    int          chars_accepted  = 0;
    int          results_checked = 0;

    base64url_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest passing run.
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results still expected", expected_results.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Map a character to its sextet value, or to whitespace, pad or invalid.
    function automatic b64d_pkg::ch_kind_t classify_char(input logic [7:0] c,
                                                         output logic [5:0] v);
        v = 6'd0;
        if (c >= "A" && c <= "Z")
        begin
            v = 6'(c - "A");
            return b64d_pkg::CH_SEXTET;
        end
        if (c >= "a" && c <= "z")
        begin
            v = 6'(c - "a" + 26);
            return b64d_pkg::CH_SEXTET;
        end
        if (c >= "0" && c <= "9")
        begin
            v = 6'(c - "0" + 52);
            return b64d_pkg::CH_SEXTET;
        end
        if (c == "+" || c == "-")
        begin
            v = 6'd62;
            return b64d_pkg::CH_SEXTET;
        end
        if (c == "/" || c == "_")
        begin
            v = 6'd63;
            return b64d_pkg::CH_SEXTET;
        end
        if (c == "=")
            return b64d_pkg::CH_PAD;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            return b64d_pkg::CH_SPACE;
        return b64d_pkg::CH_BAD;
    endfunction

    // The reported total is the count clamped to 16 bits.
    function automatic logic [15:0] reported_total();
        if (32'(decoded_bytes) > 32'hFFFF)
            return 16'hFFFF;
        return 16'(decoded_bytes);
    endfunction

    // Count one decoded byte (saturating) and build its data result.
    function automatic b64d_pkg::out_item_t byte_result(input logic [7:0] b);
        b64d_pkg::out_item_t r;
        if (decoded_bytes != '1)
            decoded_bytes = decoded_bytes + 1'b1;
        r             = '0;
        r.out_byte    = b;
        r.is_data     = 1'b1;
        r.byte_total  = reported_total();
        return r;
    endfunction

    // Advance the predictor by one accepted character and queue its results.
    task automatic predict_char(input b64d_pkg::in_item_t it);
        b64d_pkg::out_item_t batch[4];
        int                  n;
        b64d_pkg::ch_kind_t  cls;
        logic [5:0]          v;
        n = 0;
        if (it.char_present && !pad_seen && !bad_seen)
        begin
            cls = classify_char(it.char_code, v);
            case (cls)
                b64d_pkg::CH_SEXTET:
                begin
                    if (sextet_cnt == 2'd3)
                    begin
                        // Fourth sextet completes the quad: three bytes at once.
                        batch[n] = byte_result({sextet_buf[0], sextet_buf[1][5:4]});
                        n++;
                        batch[n] = byte_result({sextet_buf[1][3:0], sextet_buf[2][5:2]});
                        n++;
                        batch[n] = byte_result({sextet_buf[2][1:0], v});
                        n++;
                        sextet_cnt = 2'd0;
                    end
                    else
                    begin
                        sextet_buf[sextet_cnt] = v;
                        sextet_cnt             = sextet_cnt + 2'd1;
                    end
                end
                b64d_pkg::CH_PAD:  pad_seen = 1'b1;
                b64d_pkg::CH_BAD:  bad_seen = 1'b1;
                default: ;
            endcase
        end
        if (it.end_of_input)
        begin
            // Flush a partial quad unless an invalid character was seen;
            // a single leftover sextet carries no full byte and is dropped.
            if (!bad_seen && sextet_cnt >= 2'd2)
            begin
                batch[n] = byte_result({sextet_buf[0], sextet_buf[1][5:4]});
                n++;
            end
            if (!bad_seen && sextet_cnt == 2'd3)
            begin
                batch[n] = byte_result({sextet_buf[1][3:0], sextet_buf[2][5:2]});
                n++;
            end
            batch[n]            = '0;
            batch[n].status     = bad_seen;
            batch[n].byte_total = reported_total();
            n++;
            sextet_buf    = '{6'd0, 6'd0, 6'd0};
            sextet_cnt    = 2'd0;
            pad_seen      = 1'b0;
            bad_seen      = 1'b0;
            decoded_bytes = '0;
        end
        if (n > 0)
            batch[n-1].last_result = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor and predictor hook: sample everything at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("Unexpected result: byte 0x%0h is_data %0b",
                           result_data.out_byte, result_data.is_data);
                    errors++;
                end
                else
                begin
                    b64d_pkg::out_item_t want;
                    want = expected_results.pop_front();
                    check_field("out_byte",    16'(want.out_byte),    16'(result_data.out_byte));
                    check_field("is_data",     16'(want.is_data),     16'(result_data.is_data));
                    check_field("status",      16'(want.status),      16'(result_data.status));
                    check_field("byte_total",  want.byte_total,       result_data.byte_total);
                    check_field("last_result", 16'(want.last_result), 16'(result_data.last_result));
                end
            end
            if (char_valid && !char_stall)
            begin
                chars_accepted++;
                predict_char(char_data);
            end
        end
        char_taken <= rst_n && char_valid && !char_stall;
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge only.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            char_valid <= 1'b0;
        else if (char_valid && !char_taken)
            ; // hold the stalled transaction unchanged
        else if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            char_data  <= char_queue.pop_front();
            char_valid <= 1'b1;
        end
        else
            char_valid <= 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_LEN - 1;
            hold_done    <= 1'b1;
        end
        else
            result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [7:0] code, input logic present,
                             input logic last);
        b64d_pkg::in_item_t it;
        it.char_code    = code;
        it.char_present = present;
        it.end_of_input = last;
        char_queue.push_back(it);
        if (last)
            strings_sent++;
    endtask

    task automatic push_text(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b1, end_on_last && i == s.len() - 1);
    endtask

    // Pick a character for a sextet, mixing both alphabets for 62 and 63.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        if (v == 62)
            return $urandom_range(0, 1) ? "+" : "-";
        return $urandom_range(0, 1) ? "/" : "_";
    endfunction

    // One random string: mostly well-formed Base64 with random content, some
    // broken on purpose, and some pure noise.
    task automatic gen_string();
        int          mode;
        int          nbytes;
        int          n;
        int          ws;
        bit          use_pad;
        bit          end_on_char;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  txt[$];
        mode = $urandom_range(0, 99);
        if (mode >= 90)
        begin
            // Noise: any byte, present or not.
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == n - 1);
            chars_planned += n;
            return;
        end
        use_pad = $urandom_range(0, 1);
        nbytes  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 9);
        for (int i = 0; i < nbytes; i += 3)
        begin
            b0 = 8'($urandom);
            b1 = 8'($urandom);
            b2 = 8'($urandom);
            txt.push_back(sextet_char(b0[7:2]));
            txt.push_back(sextet_char({b0[1:0], b1[7:4]}));
            if (nbytes - i >= 2)
                txt.push_back(sextet_char({b1[3:0], b2[7:6]}));
            else if (use_pad)
                txt.push_back("=");
            if (nbytes - i >= 3)
                txt.push_back(sextet_char(b2[5:0]));
            else if (use_pad)
                txt.push_back("=");
        end
        if (mode >= 72)
        begin
            // Break the string: corrupt a char, drop one, or add junk after a pad.
            case ($urandom_range(0, 2))
                0:
                    if (txt.size() > 0)
                        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                1:
                    if (txt.size() > 0)
                        txt.delete($urandom_range(0, txt.size() - 1));
                default:
                begin
                    txt.push_back("=");
                    repeat ($urandom_range(1, 4))
                        txt.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        end_on_char = (txt.size() > 0) && $urandom_range(0, 1);
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                ws = $urandom_range(0, 5);
                push_char((ws == 5) ? 8'h20 : 8'(8'h09 + ws), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 19) == 0)
                push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_char(txt[i], 1'b1, end_on_char && i == txt.size() - 1);
        end
        // Close with a bare end marker whose char_code must be ignored.
        if (!end_on_char)
            push_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        chars_planned += txt.size() + 1;
    endtask

    task automatic gen_until(input int target);
        while (chars_planned < target)
            gen_string();
    endtask

    // Pause the sender until every queued transaction and result has gone.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (char_queue.size() != 0 || char_valid || expected_results.size() != 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed strings.
        // Both alphabets and the sextet extremes, an absent character, and a
        // bare end marker with a nonzero code.
        push_text("Az09+/-_", 1'b0);
        push_char("A", 1'b0, 1'b0);
        push_char(8'hFF, 1'b0, 1'b1);
        // Whitespace between sextets; two leftovers flush one byte.
        push_char("Q", 1'b1, 1'b0);
        push_char(8'h09, 1'b1, 1'b0);
        push_char("Q", 1'b1, 1'b0);
        push_char(8'h20, 1'b1, 1'b0);
        push_char(8'h0D, 1'b1, 1'b0);
        push_char(8'h00, 1'b0, 1'b1);
        // Three leftovers flush two bytes; a single leftover is dropped.
        push_text("QUJ", 1'b1);
        push_text("Q", 1'b1);
        // Characters after a pad are ignored, invalid ones too.
        push_text("QQ=", 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        push_char("A", 1'b1, 1'b1);
        // An invalid character blocks the flush and flags the status.
        push_text("QQ", 1'b0);
        push_char(8'h00, 1'b1, 1'b0);
        push_char("Q", 1'b1, 1'b1);
        wait_drained();

        // Random strings, then a long receiver hold-off while the sender keeps
        // offering, so the decoder fills and stalls its input.
        gen_until(chars_planned + 130);
        hold_req = 1'b1;
        while (char_queue.size() > 5)
            @(posedge clk);

        // A stretch with no idling on either side.
        calm = 1'b1;
        gen_until(chars_planned + 120);
        wait_drained();
        calm = 1'b0;

        gen_until(chars_planned + 100);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Decoded %0d strings from %0d characters; %0d results checked.",
                 strings_sent, chars_accepted, results_checked);
        $display("Long receiver hold-off with a full decoder applied: %0b.", hold_done);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
